// ===== hdl/lfpd_pkg.sv =====
`default_nettype none

package lfpd_pkg;

	// field and register widths
	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned DUTY_W   = 8;
	localparam int unsigned ALPHA_W  = 9;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 12;

	// shared unit widths
	localparam int unsigned OPA_W  = 20;
	localparam int unsigned OPB_W  = 9;
	localparam int unsigned PROD_W = OPA_W + OPB_W + 1;
	localparam int unsigned ACC_W  = 24;
	localparam int unsigned FILT_W = 20;
	localparam int unsigned TERM_W = FILT_W - 8;
	localparam int unsigned SPEED_W = 13;

	// gains per error magnitude
	localparam logic [7:0] KP_CENTER = 8'd25;
	localparam logic [7:0] KD_CENTER = 8'd140;
	localparam logic [7:0] KP_SOFT   = 8'd23;
	localparam logic [7:0] KD_SOFT   = 8'd160;
	localparam logic [7:0] KP_HARD   = 8'd220;
	localparam logic [7:0] KD_HARD   = 8'd100;

	// filter and speed limits
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
	localparam logic signed [ACC_W-1:0] FILT_MAX = 24'sd524287;
	localparam logic signed [ACC_W-1:0] FILT_MIN = -24'sd524288;
	localparam logic signed [SPEED_W-1:0] SPEED_MIN = -13'sd120;
	localparam logic signed [SPEED_W-1:0] SPEED_MAX = 13'sd255;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLACK_THRESHOLD = 3'd0,
		CFG_BASE_STRAIGHT   = 3'd1,
		CFG_BASE_SOFT       = 3'd2,
		CFG_BASE_HARD       = 3'd3,
		CFG_ALPHA_Q8        = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] left_sample;
		logic [SAMPLE_W-1:0] center_sample;
		logic [SAMPLE_W-1:0] right_sample;
	} in_beat_t;

	typedef struct packed {
		logic [DUTY_W-1:0] left_duty;
		logic              left_reverse;
		logic [DUTY_W-1:0] right_duty;
		logic              right_reverse;
	} out_beat_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASS,
		ST_KP,
		ST_KD,
		ST_ALPHA,
		ST_DECAY,
		ST_SAT,
		ST_OUT
	} st_t;

	// operand pair for the shared multiply-add
	typedef enum logic [1:0] {
		OP_KP,
		OP_KD,
		OP_ALPHA,
		OP_DECAY
	} opsel_t;

	typedef struct packed {
		logic   in_ready;
		logic   class_en;
		logic   mac_en;
		logic   mac_clear;
		logic   mac_shift;
		opsel_t op_sel;
		logic   sat_en;
		logic   out_load;
	} ctrl_t;

	// sensor pattern {left, center, right} to steering error
	function automatic logic signed [2:0] err_map(input logic [2:0] lcr);
		logic signed [2:0] e;
		unique case (lcr)
			3'b011: e = 3'sd1;
			3'b001: e = 3'sd2;
			3'b110: e = -3'sd1;
			3'b100: e = -3'sd2;
			default: e = 3'sd0;
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/line_follow_pd_steering_unit.sv =====
// channel | direction | payload    | handshake
// in      | into unit | in_beat_t  | in_valid / in_stall
// out     | from unit | out_beat_t | out_valid / out_stall
// cfg     | into unit | cfg_data   | cfg_wen, cfg_index
//
// a steering beat steps through the sequencer from acceptance to the next acceptance: the single
// multiply-add unit runs four passes (kp, kd, alpha, decay) then saturate and output.
// a beat with no sensor or all sensors on the line skips the multiplies.
// reset clears the configuration to its defaults and the filter state to zero.
// while the result register is held by out_stall the unit waits in its output step;
// a finished result in the register does not block the next input beat.
`default_nettype none

module line_follow_pd_steering_unit
	import lfpd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_beat_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_beat_t                  out_data,
	input  wire logic                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	ctrl_t ctrl;

	logic [SAMPLE_W-1:0] thr_q;
	logic [DUTY_W-1:0]   base_str_q;
	logic [DUTY_W-1:0]   base_soft_q;
	logic [DUTY_W-1:0]   base_hard_q;
	logic [ALPHA_W-1:0]  alpha_q;

	in_beat_t                 in_q;
	logic signed [2:0]        prior_q;
	logic signed [FILT_W-1:0] filt_q;
	logic signed [2:0]        err_q;
	logic signed [3:0]        d_q;
	logic [7:0]               kp_q;
	logic [7:0]               kd_q;
	logic [DUTY_W-1:0]        base_q;
	logic                     bypass_q;
	logic                     out_valid_q;
	out_beat_t                out_q;

	logic [2:0]               seen;
	logic                     bypass;
	logic signed [2:0]        err;
	logic [ALPHA_W-1:0]       alpha_sat;
	logic signed [OPA_W-1:0]  op_a;
	logic [OPB_W-1:0]         op_b;
	logic signed [ACC_W-1:0]  acc;
	logic                     in_fire;
	logic                     out_free;
	logic signed [TERM_W-1:0] term;
	logic signed [SPEED_W-1:0] speed_l;
	logic signed [SPEED_W-1:0] speed_r;

	// clamp a speed and split it into duty and direction
	function automatic logic [DUTY_W:0] to_motor(input logic signed [SPEED_W-1:0] sp);
		logic signed [SPEED_W-1:0] neg;
		logic [DUTY_W:0]           r;
		neg = -sp;
		if (sp < SPEED_MIN) begin
			r = {8'd120, 1'b1};
		end else if (sp > SPEED_MAX) begin
			r = {8'd255, 1'b0};
		end else if (sp < 0) begin
			r = {neg[DUTY_W-1:0], 1'b1};
		end else begin
			r = {sp[DUTY_W-1:0], 1'b0};
		end
		return r;
	endfunction

	lfpd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.bypass   (bypass),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	lfpd_mac u_mac (
		.clk   (clk),
		.en    (ctrl.mac_en),
		.clear (ctrl.mac_clear),
		.shift (ctrl.mac_shift),
		.op_a  (op_a),
		.op_b  (op_b),
		.acc   (acc)
	);

	// handshake
	assign in_stall  = !ctrl.in_ready;
	assign in_fire   = in_valid && ctrl.in_ready;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= 12'd500;
			base_str_q  <= 8'd230;
			base_soft_q <= 8'd130;
			base_hard_q <= 8'd80;
			alpha_q     <= 9'd77;
		end else if (cfg_wen) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BLACK_THRESHOLD: thr_q       <= cfg_data;
				CFG_BASE_STRAIGHT:   base_str_q  <= cfg_data[DUTY_W-1:0];
				CFG_BASE_SOFT:       base_soft_q <= cfg_data[DUTY_W-1:0];
				CFG_BASE_HARD:       base_hard_q <= cfg_data[DUTY_W-1:0];
				CFG_ALPHA_Q8:        alpha_q     <= cfg_data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			in_q <= in_data;
		end
	end

	// line detection and error
	always_comb begin
		seen[2]   = in_q.left_sample < thr_q;
		seen[1]   = in_q.center_sample < thr_q;
		seen[0]   = in_q.right_sample < thr_q;
		bypass    = (seen == 3'b000) || (seen == 3'b111);
		err       = err_map(seen);
		alpha_sat = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	end

	// per-beat gains, base duty and derivative
	always_ff @(posedge clk) begin
		if (ctrl.class_en) begin
			err_q    <= err;
			d_q      <= 4'(err) - 4'(prior_q);
			bypass_q <= bypass;
			priority if (bypass || err == 3'sd0) begin
				kp_q   <= KP_CENTER;
				kd_q   <= KD_CENTER;
				base_q <= base_str_q;
			end else if (err == 3'sd1 || err == -3'sd1) begin
				kp_q   <= KP_SOFT;
				kd_q   <= KD_SOFT;
				base_q <= base_soft_q;
			end else begin
				kp_q   <= KP_HARD;
				kd_q   <= KD_HARD;
				base_q <= base_hard_q;
			end
		end
	end

	// controller state: prior error and filtered term
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_q <= '0;
			filt_q  <= '0;
		end else begin
			if (ctrl.class_en) begin
				if (seen == 3'b111) begin
					prior_q <= '0;
					filt_q  <= '0;
				end else if (!bypass) begin
					prior_q <= err;
				end
			end
			if (ctrl.sat_en) begin
				if (acc > FILT_MAX) begin
					filt_q <= FILT_MAX[FILT_W-1:0];
				end else if (acc < FILT_MIN) begin
					filt_q <= FILT_MIN[FILT_W-1:0];
				end else begin
					filt_q <= acc[FILT_W-1:0];
				end
			end
		end
	end

	// operand select for the shared multiply-add
	always_comb begin
		unique case (ctrl.op_sel)
			OP_KP: begin
				op_a = OPA_W'(err_q);
				op_b = {1'b0, kp_q};
			end
			OP_KD: begin
				op_a = OPA_W'(d_q);
				op_b = {1'b0, kd_q};
			end
			OP_ALPHA: begin
				op_a = acc[OPA_W-1:0];
				op_b = alpha_sat;
			end
			OP_DECAY: begin
				op_a = filt_q;
				op_b = ALPHA_ONE - alpha_sat;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// filtered term truncated toward zero, then motor speeds
	always_comb begin
		term = filt_q[FILT_W-1:8];
		if (filt_q[FILT_W-1] && (filt_q[7:0] != 8'd0)) begin
			term = term + TERM_W'(1);
		end
		if (bypass_q) begin
			term = '0;
		end
		speed_l = $signed({5'b0, base_q}) - SPEED_W'(term);
		speed_r = $signed({5'b0, base_q}) + SPEED_W'(term);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			{out_q.left_duty, out_q.left_reverse}   <= to_motor(speed_l);
			{out_q.right_duty, out_q.right_reverse} <= to_motor(speed_r);
		end
	end

`ifndef SYNTHESIS
	// an accepted beat keeps the unit busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted twice in a row");

	// reverse duty never beyond the reverse limit
	a_left_rev_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.left_reverse) |->
		(out_data.left_duty <= 8'd120 && out_data.left_duty != 8'd0))
		else $error("left reverse duty out of range");

	a_right_rev_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.right_reverse) |->
		(out_data.right_duty <= 8'd120 && out_data.right_duty != 8'd0))
		else $error("right reverse duty out of range");

	// a result loads only into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.out_load |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

// ===== hdl/lfpd_mac.sv =====
`default_nettype none

module lfpd_mac
	import lfpd_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic                    clear,
	input  wire logic                    shift,
	input  wire logic signed [OPA_W-1:0] op_a,
	input  wire logic [OPB_W-1:0]        op_b,
	output logic signed [ACC_W-1:0]      acc
);

	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_sh;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  acc_q;

	// signed by unsigned multiply, optional floor divide by 256
	always_comb begin
		prod    = PROD_W'(op_a) * PROD_W'($signed({1'b0, op_b}));
		prod_sh = prod >>> 8;
		addend  = shift ? prod_sh[ACC_W-1:0] : prod[ACC_W-1:0];
	end

	// accumulator
	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= (clear ? '0 : acc_q) + addend;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

// ===== hdl/lfpd_seq.sv =====
`default_nettype none

module lfpd_seq
	import lfpd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic bypass,
	input  wire logic out_free,
	output ctrl_t     ctrl
);

	st_t state_q;
	st_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = ST_CLASS;
			ST_CLASS: state_nxt = bypass ? ST_OUT : ST_KP;
			ST_KP:    state_nxt = ST_KD;
			ST_KD:    state_nxt = ST_ALPHA;
			ST_ALPHA: state_nxt = ST_DECAY;
			ST_DECAY: state_nxt = ST_SAT;
			ST_SAT:   state_nxt = ST_OUT;
			ST_OUT:   if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		ctrl = '0;
		ctrl.op_sel = OP_KP;
		unique case (state_q)
			ST_IDLE: ctrl.in_ready = 1'b1;
			ST_CLASS: ctrl.class_en = 1'b1;
			ST_KP: begin
				ctrl.mac_en    = 1'b1;
				ctrl.mac_clear = 1'b1;
				ctrl.op_sel    = OP_KP;
			end
			ST_KD: begin
				ctrl.mac_en = 1'b1;
				ctrl.op_sel = OP_KD;
			end
			ST_ALPHA: begin
				ctrl.mac_en    = 1'b1;
				ctrl.mac_clear = 1'b1;
				ctrl.op_sel    = OP_ALPHA;
			end
			ST_DECAY: begin
				ctrl.mac_en    = 1'b1;
				ctrl.mac_shift = 1'b1;
				ctrl.op_sel    = OP_DECAY;
			end
			ST_SAT: ctrl.sat_en = 1'b1;
			ST_OUT: ctrl.out_load = out_free;
			default: ctrl = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== tb/steering_checker.sv =====
`default_nettype none

module steering_checker
	import lfpd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire in_beat_t              in_data,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire out_beat_t             out_data,
	input  wire logic                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         mismatches,
	output int                         awaiting
);

	localparam longint FILTER_HI = 524287;
	localparam longint FILTER_LO = -524288;
	localparam longint DRIVE_HI  = 255;
	localparam longint DRIVE_LO  = -120;
	localparam int     ALPHA_CAP = 256;

	// shadow copy of the unit's registers and loop state
	logic [SAMPLE_W-1:0] line_level;
	logic [DUTY_W-1:0]   cruise_duty;
	logic [DUTY_W-1:0]   soft_duty;
	logic [DUTY_W-1:0]   hard_duty;
	logic [ALPHA_W-1:0]  blend_weight;
	int                  last_error;
	longint              smoothed_q8;

	out_beat_t drive_expected[$];
	out_beat_t oldest;

	// clamp one wheel speed and split it into magnitude and direction
	function automatic logic [DUTY_W:0] wheel_cmd(longint speed);
		longint v;
		v = speed;
		if (v < DRIVE_LO)
			v = DRIVE_LO;
		if (v > DRIVE_HI)
			v = DRIVE_HI;
		if (v < 0)
			return {DUTY_W'(-v), 1'b1};
		return {DUTY_W'(v), 1'b0};
	endfunction

	// next motor command for one sensor beat, advancing the loop state
	function automatic out_beat_t predict_drive(in_beat_t b);
		logic [2:0] seen;
		int         e;
		int         d;
		int         kp;
		int         kd;
		int         base;
		longint     raw;
		longint     a;
		longint     s;
		longint     t;
		out_beat_t  res;
		seen = {b.left_sample < line_level, b.center_sample < line_level,
			b.right_sample < line_level};
		res = {cruise_duty, 1'b0, cruise_duty, 1'b0};
		// line lost: straight ahead, loop state kept
		if (seen == 3'b000)
			return res;
		// crossing or stop bar: straight ahead, loop state cleared
		if (seen == 3'b111) begin
			last_error = 0;
			smoothed_q8 = 0;
			return res;
		end
		case (seen)
			3'b011: e = 1;
			3'b001: e = 2;
			3'b110: e = -1;
			3'b100: e = -2;
			default: e = 0;
		endcase
		d = e - last_error;
		last_error = e;
		// gain schedule by error magnitude
		case (e)
			0: begin
				kp = 25;
				kd = 140;
				base = int'(cruise_duty);
			end
			1, -1: begin
				kp = 23;
				kd = 160;
				base = int'(soft_duty);
			end
			default: begin
				kp = 220;
				kd = 100;
				base = int'(hard_duty);
			end
		endcase
		raw = kp * e + kd * d;
		a = (blend_weight > ALPHA_CAP) ? ALPHA_CAP : blend_weight;
		// exponential filter, decay product floored
		s = a * raw + (((256 - a) * smoothed_q8) >>> 8);
		if (s > FILTER_HI)
			s = FILTER_HI;
		if (s < FILTER_LO)
			s = FILTER_LO;
		smoothed_q8 = s;
		t = s / 256;
		{res.left_duty, res.left_reverse} = wheel_cmd(base - t);
		{res.right_duty, res.right_reverse} = wheel_cmd(base + t);
		return res;
	endfunction

	task automatic compare_field(string field, int want, int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// watch the three ports at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_level = 500;
			cruise_duty = 230;
			soft_duty = 130;
			hard_duty = 80;
			blend_weight = 77;
			last_error = 0;
			smoothed_q8 = 0;
			drive_expected.delete();
			mismatches = 0;
			awaiting = 0;
		end else begin
			// result beat against the oldest prediction
			if (out_valid && !out_stall) begin
				if (drive_expected.size() == 0) begin
					mismatches++;
					$display("%0t: result beat with nothing expected, expected none, actual %p",
						$time, out_data);
				end else begin
					oldest = drive_expected.pop_front();
					compare_field("left_duty", oldest.left_duty, out_data.left_duty);
					compare_field("left_reverse", oldest.left_reverse, out_data.left_reverse);
					compare_field("right_duty", oldest.right_duty, out_data.right_duty);
					compare_field("right_reverse", oldest.right_reverse, out_data.right_reverse);
				end
			end
			// register writes
			if (cfg_wen) begin
				case (cfg_idx_t'(cfg_index))
					CFG_BLACK_THRESHOLD: line_level = cfg_data[SAMPLE_W-1:0];
					CFG_BASE_STRAIGHT:   cruise_duty = cfg_data[DUTY_W-1:0];
					CFG_BASE_SOFT:       soft_duty = cfg_data[DUTY_W-1:0];
					CFG_BASE_HARD:       hard_duty = cfg_data[DUTY_W-1:0];
					CFG_ALPHA_Q8:        blend_weight = cfg_data[ALPHA_W-1:0];
					default: ;
				endcase
			end
			// sensor beat accepted
			if (in_valid && !in_stall)
				drive_expected.push_back(predict_drive(in_data));
			awaiting = drive_expected.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
	import lfpd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 12;
	localparam int PHASE_BEATS = 105;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_beat_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_beat_t             out_data;
	logic                  cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int mismatches;
	int awaiting;
	int cycle_count = 0;
	bit calm = 1'b0;
	int track_pos = 0;
	logic [SAMPLE_W-1:0] level_now = 500;

	line_follow_pd_steering_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	steering_checker drive_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench: done, errors");
		$finish;
	end

	// result side back-pressure in short bursts
	initial begin
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			out_stall = 1'b0;
		end
	end

	// one sensor beat, with an occasional gap before it
	task automatic send_beat(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] c,
		logic [SAMPLE_W-1:0] r);
		@(negedge clk);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_data.left_sample = l;
		in_data.center_sample = c;
		in_data.right_sample = r;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// hold off until every result is back and the unit has gone idle
	task automatic quiesce();
		@(negedge clk);
		in_valid = 1'b0;
		while (awaiting != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
	endtask

	task automatic configure(logic [SAMPLE_W-1:0] level, logic [DUTY_W-1:0] cruise,
		logic [DUTY_W-1:0] soft_base, logic [DUTY_W-1:0] hard_base,
		logic [ALPHA_W-1:0] weight);
		quiesce();
		set_reg(CFG_BLACK_THRESHOLD, level);
		set_reg(CFG_BASE_STRAIGHT, CFG_DATA_W'(cruise));
		set_reg(CFG_BASE_SOFT, CFG_DATA_W'(soft_base));
		set_reg(CFG_BASE_HARD, CFG_DATA_W'(hard_base));
		set_reg(CFG_ALPHA_Q8, CFG_DATA_W'(weight));
		@(negedge clk);
		cfg_wen = 1'b0;
		level_now = level;
	endtask

	// a reading on or off the line under the current threshold, boundaries favored
	function automatic logic [SAMPLE_W-1:0] pick_sample(bit on_line);
		if (on_line && level_now != 0) begin
			if ($urandom_range(0, 7) == 0)
				return level_now - 1;
			return SAMPLE_W'($urandom_range(0, level_now - 1));
		end
		if (on_line)
			return SAMPLE_W'($urandom_range(0, 4095));
		if ($urandom_range(0, 7) == 0)
			return level_now;
		return SAMPLE_W'($urandom_range(level_now, 4095));
	endfunction

	function automatic logic [2:0] lane_pattern(int pos);
		case (pos)
			-2: return 3'b100;
			-1: return 3'b110;
			1: return 3'b011;
			2: return 3'b001;
			default: return 3'b010;
		endcase
	endfunction

	// mostly a wandering track, some lost line, bars, odd patterns and raw noise
	task automatic send_random();
		int k;
		logic [2:0] lcr;
		k = $urandom_range(0, 99);
		if (k < 65) begin
			if ($urandom_range(0, 4) == 0)
				track_pos = $urandom_range(0, 4) - 2;
			else
				track_pos += $urandom_range(0, 2) - 1;
			if (track_pos > 2)
				track_pos = 2;
			if (track_pos < -2)
				track_pos = -2;
			lcr = lane_pattern(track_pos);
		end else if (k < 75) begin
			lcr = 3'b000;
		end else if (k < 83) begin
			lcr = 3'b111;
		end else if (k < 90) begin
			lcr = 3'b101;
		end else begin
			send_beat(SAMPLE_W'($urandom_range(0, 4095)), SAMPLE_W'($urandom_range(0, 4095)),
				SAMPLE_W'($urandom_range(0, 4095)));
			return;
		end
		send_beat(pick_sample(lcr[2]), pick_sample(lcr[1]), pick_sample(lcr[0]));
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// directed: every sensor pattern at reset settings, threshold boundary, big swings
		send_beat(4095, 4095, 4095);
		send_beat(0, 0, 0);
		send_beat(4095, 0, 4095);
		send_beat(4095, 0, 0);
		send_beat(4095, 4095, 0);
		send_beat(0, 0, 4095);
		send_beat(0, 4095, 4095);
		send_beat(4095, 4095, 0);
		send_beat(0, 4095, 4095);
		send_beat(0, 4095, 4095);
		send_beat(0, 4095, 0);
		send_beat(499, 500, 499);
		send_beat(500, 499, 500);
		send_beat(4095, 4095, 4095);
		send_beat(4095, 0, 0);
		send_beat(0, 0, 0);
		send_beat(0, 4095, 4095);

		// zero threshold sees nothing, zero weight and bases
		configure(0, 0, 0, 0, 0);
		send_beat(0, 0, 0);
		send_beat(4095, 2048, 1);

		// full threshold, full bases, weight above one
		configure(4095, 255, 255, 255, 511);
		send_beat(4094, 4095, 4095);
		send_beat(4095, 4095, 4094);
		send_beat(0, 0, 0);
		send_beat(4095, 4094, 4095);

		// random phases, each with its own settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: configure(SAMPLE_W'($urandom_range(200, 3500)),
					DUTY_W'($urandom_range(0, 255)), DUTY_W'($urandom_range(0, 255)),
					DUTY_W'($urandom_range(0, 255)), ALPHA_W'($urandom_range(0, 256)));
				1: configure(4095, 255, 255, 255, 256);
				2: configure(1, 0, 0, 0, 1);
				3: configure(SAMPLE_W'($urandom_range(1, 4095)),
					DUTY_W'($urandom_range(0, 255)), DUTY_W'($urandom_range(0, 255)),
					DUTY_W'($urandom_range(0, 255)), ALPHA_W'($urandom_range(257, 511)));
				4: configure(SAMPLE_W'($urandom_range(100, 4000)), 230, 130, 80, 255);
				default: configure(SAMPLE_W'($urandom_range(1, 4095)),
					DUTY_W'($urandom_range(0, 255)), DUTY_W'($urandom_range(0, 255)),
					DUTY_W'($urandom_range(0, 255)), ALPHA_W'($urandom_range(0, 256)));
			endcase
			if (ph == 5)
				calm = 1'b1;
			track_pos = 0;
			repeat (PHASE_BEATS) send_random();
		end

		quiesce();
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
